// File: rtl/rlbt_pkg.sv
// shared constants, types and the arctangent table for the bearing tracker
// used by rlbt_ctrl, rlbt_dp and rate_limited_bearing_tracker
package rlbt_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COORD_BITS = 24;
  localparam int FIELD_BITS = 16;
  localparam int RATE_BITS = 20;
  localparam int TIME_BITS = 20;

  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int SCALE_SHIFT = 56 - COORD_BITS;
  localparam int CW = 60;

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_BITS = $clog2(CORDIC_STEPS);
  localparam int ZW = 32;

  // floor(p / 1000000) as ((p >> 6) * RECIP) >> 48, exact for p below 2^40
  localparam int PROD_BITS = RATE_BITS + TIME_BITS;
  localparam int PRE_SHIFT = 6;
  localparam int NUM_BITS = PROD_BITS - PRE_SHIFT;
  localparam int RLO_BITS = 17;
  localparam int RHI_BITS = 18;
  localparam int ACC_BITS = NUM_BITS + RLO_BITS + RHI_BITS;
  localparam int RECIP_SHIFT = 48;
  localparam logic [RLO_BITS+RHI_BITS-1:0] RECIP = 35'd18014398510;
  localparam int LIM_BITS = ACC_BITS - RECIP_SHIFT;
  localparam int LIM_STEPS = 2;

  localparam int CMP_BITS = 32;

  localparam logic [RATE_BITS-1:0] TURN_RATE_RESET = RATE_BITS'(16384);

  localparam int ADDR_BITS = 3;
  localparam logic [0:0] REG_TURN_RATE = 1'b0;

  localparam logic ACT_TRACK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef struct packed {
    logic                 capture;
    logic                 prep;
    logic                 iter;
    logic                 div_en;
    logic [STEP_BITS-1:0] step;
    logic                 bear;
    logic                 finish;
  } rlbt_cmd_t;

  typedef struct packed {
    logic action;
  } rlbt_sts_t;

  function automatic logic [ZW-1:0] atan_of(input logic [STEP_BITS-1:0] i);
    logic [ZW-1:0] t;
    case (i)
      5'd0: t = 32'd536870912;
      5'd1: t = 32'd316933406;
      5'd2: t = 32'd167458907;
      5'd3: t = 32'd85004756;
      5'd4: t = 32'd42667331;
      5'd5: t = 32'd21354465;
      5'd6: t = 32'd10679838;
      5'd7: t = 32'd5340245;
      5'd8: t = 32'd2670163;
      5'd9: t = 32'd1335087;
      5'd10: t = 32'd667544;
      5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;
      5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;
      5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;
      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;
      5'd21: t = 32'd326;
      5'd22: t = 32'd163;
      5'd23: t = 32'd81;
      5'd24: t = 32'd41;
      5'd25: t = 32'd20;
      5'd26: t = 32'd10;
      5'd27: t = 32'd5;
      5'd28: t = 32'd3;
      5'd29: t = 32'd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/rlbt_ctrl.sv
// sequencer for the bearing tracker: accept, setup, cordic steps, bearing, update
// depends on rlbt_pkg; drives rlbt_dp through rlbt_cmd_t
module rlbt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  rlbt_pkg::rlbt_sts_t sts,
  output rlbt_pkg::rlbt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ITER,
    S_BEAR,
    S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [rlbt_pkg::STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           accept;
  logic                           finish;

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && (state_r == S_IDLE);
  assign finish = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.capture = accept;
    cmd.prep = (state_r == S_PREP);
    cmd.iter = (state_r == S_ITER);
    cmd.div_en = (state_r == S_ITER) &&
                 (cnt_r < rlbt_pkg::STEP_BITS'(rlbt_pkg::LIM_STEPS));
    cmd.step = cnt_r;
    cmd.bear = (state_r == S_BEAR);
    cmd.finish = finish;

    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cnt_nxt = '0;
        if (sts.action == rlbt_pkg::ACT_LOAD) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ITER;
        end
      end
      S_ITER: begin
        if (cnt_r == rlbt_pkg::STEP_BITS'(rlbt_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = S_BEAR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_BEAR: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (finish) begin
          state_nxt = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ITER) |-> (cnt_r < rlbt_pkg::STEP_BITS'(rlbt_pkg::CORDIC_STEPS)))
    else $error("cordic step count out of range");
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_PREP))
    else $error("accepted transfer did not start setup");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result written over a pending transfer");
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("finished item not presented");
`endif

endmodule

// File: rtl/rlbt_dp.sv
// datapath of the bearing tracker: cordic vectoring, rate limit by reciprocal multiply,
// heading update; depends on rlbt_pkg; sequenced by rlbt_ctrl
module rlbt_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  rlbt_pkg::rlbt_cmd_t                     cmd,
  output rlbt_pkg::rlbt_sts_t                     sts,
  input  logic [rlbt_pkg::RATE_BITS-1:0]          turn_rate,
  input  logic                                   in_action,
  input  logic [rlbt_pkg::TIME_BITS-1:0]          in_elapsed_us,
  input  logic signed [rlbt_pkg::COORD_BITS-1:0]  in_own_x,
  input  logic signed [rlbt_pkg::COORD_BITS-1:0]  in_own_y,
  input  logic signed [rlbt_pkg::COORD_BITS-1:0]  in_target_x,
  input  logic signed [rlbt_pkg::COORD_BITS-1:0]  in_target_y,
  input  logic [rlbt_pkg::FIELD_BITS-1:0]         in_new_heading,
  output logic [rlbt_pkg::FIELD_BITS-1:0]         out_heading,
  output logic [rlbt_pkg::FIELD_BITS-1:0]         out_bearing
);

  localparam int AB = rlbt_pkg::ANGLE_BITS;
  localparam int CW = rlbt_pkg::CW;
  localparam int DB = rlbt_pkg::DIFF_BITS;
  localparam int PB = rlbt_pkg::PROD_BITS;
  localparam int NB = rlbt_pkg::CMP_BITS;
  localparam int ZW = rlbt_pkg::ZW;
  localparam int AW = rlbt_pkg::ACC_BITS;
  localparam int MB = rlbt_pkg::NUM_BITS;
  localparam int RL = rlbt_pkg::RLO_BITS;
  localparam int RH = rlbt_pkg::RHI_BITS;
  localparam int RW = RL + RH;
  localparam int PW = MB + RH;
  localparam logic [RW-1:0] RECIP = rlbt_pkg::RECIP;

  logic                                action_r;
  logic [rlbt_pkg::TIME_BITS-1:0]      elapsed_r;
  logic [rlbt_pkg::FIELD_BITS-1:0]     new_heading_r;
  logic signed [DB-1:0]                dx_r;
  logic signed [DB-1:0]                dy_r;
  logic                                zero_r;
  logic signed [CW-1:0]                x_r;
  logic signed [CW-1:0]                y_r;
  logic [ZW-1:0]                       z_r;
  logic [PB-1:0]                       prod_r;
  logic [AW-1:0]                       acc_r;
  logic [AB-1:0]                       bearing_r;
  logic [AB-1:0]                       cur_r, cur_nxt;
  logic [rlbt_pkg::FIELD_BITS-1:0]     out_heading_r;
  logic [rlbt_pkg::FIELD_BITS-1:0]     out_bearing_r;

  logic signed [CW-1:0]                x0, y0, xs, ys;
  logic [ZW-1:0]                       atan_v;
  logic [MB-1:0]                       num;
  logic [RH-1:0]                       mul_k;
  logic [PW-1:0]                       pp;
  logic [AW-1:0]                       pp_sh;
  logic [ZW-1:0]                       zr;
  logic [AB-1:0]                       u;
  logic signed [NB-1:0]                d, lim, d_cl;
  logic [31:0]                         nh_wide, cur_wide, bear_wide;
  logic [AB-1:0]                       bear_sel;

  assign sts.action = action_r;

  always_comb begin
    x0 = CW'(dy_r) <<< rlbt_pkg::SCALE_SHIFT;
    y0 = CW'(dx_r) <<< rlbt_pkg::SCALE_SHIFT;
    xs = x_r >>> cmd.step;
    ys = y_r >>> cmd.step;
    atan_v = rlbt_pkg::atan_of(cmd.step);
    zr = (ZW'(0) - z_r) + (ZW'(1) << (ZW - 1 - AB));

    // low reciprocal half on the first step, high half on the second
    num = prod_r[PB-1:rlbt_pkg::PRE_SHIFT];
    mul_k = (cmd.step == '0) ? RH'(RECIP[RL-1:0]) : RECIP[RW-1:RL];
    pp = PW'(num) * PW'(mul_k);
    pp_sh = (cmd.step == '0) ? AW'(pp) : (AW'(pp) << RL);

    bear_sel = (action_r == rlbt_pkg::ACT_LOAD) ? '0 : bearing_r;
    u = bearing_r - cur_r;
    if (u > (AB'(1) << (AB - 1))) begin
      d = NB'(u) - (NB'(1) << AB);
    end else begin
      d = NB'(u);
    end
    lim = NB'(acc_r[AW-1:rlbt_pkg::RECIP_SHIFT]);
    if (d > lim) begin
      d_cl = lim;
    end else if (d < -lim) begin
      d_cl = -lim;
    end else begin
      d_cl = d;
    end
    nh_wide = 32'(new_heading_r);
    if (action_r == rlbt_pkg::ACT_LOAD) begin
      cur_nxt = nh_wide[AB-1:0];
    end else begin
      cur_nxt = cur_r + d_cl[AB-1:0];
    end
    cur_wide = 32'(cur_nxt);
    bear_wide = 32'(bear_sel);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_action;
      elapsed_r <= in_elapsed_us;
      new_heading_r <= in_new_heading;
      dx_r <= DB'(in_own_x) - DB'(in_target_x);
      dy_r <= DB'(in_own_y) - DB'(in_target_y);
    end
    if (cmd.prep) begin
      zero_r <= (dx_r == '0) && (dy_r == '0);
      prod_r <= PB'(turn_rate) * PB'(elapsed_r);
      acc_r <= '0;
      if (dy_r < 0) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= ZW'(1) << (ZW - 1);
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end
    if (cmd.iter) begin
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_v;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_v;
      end
    end
    if (cmd.div_en) begin
      acc_r <= acc_r + pp_sh;
    end
    if (cmd.bear) begin
      bearing_r <= zero_r ? '0 : zr[ZW-1 -: AB];
    end
    if (cmd.finish) begin
      out_heading_r <= cur_wide[rlbt_pkg::FIELD_BITS-1:0];
      out_bearing_r <= bear_wide[rlbt_pkg::FIELD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else if (cmd.finish) begin
      cur_r <= cur_nxt;
    end
  end

  assign out_heading = out_heading_r;
  assign out_bearing = out_bearing_r;

endmodule

// File: rtl/rate_limited_bearing_tracker.sv
// Turns a kept heading toward the bearing of a target, at most turn_rate angle units per
// second. A track item computes the bearing with a 30-step iterative CORDIC (one step per
// cycle) while a two-step reciprocal multiply finds the turn limit; the block takes a new
// item only once the previous one is through accept, setup, 30 CORDIC steps, bearing
// rounding and heading update, a load item through accept, setup and heading update. The
// output register lets the next item be accepted while a result still waits for transfer.
// top level: apb register for turn_rate, instances of rlbt_ctrl and rlbt_dp
// depends on rlbt_pkg
module rate_limited_bearing_tracker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_action,
  input  logic [rlbt_pkg::TIME_BITS-1:0]          in_elapsed_us,
  input  logic signed [rlbt_pkg::COORD_BITS-1:0]  in_own_x,
  input  logic signed [rlbt_pkg::COORD_BITS-1:0]  in_own_y,
  input  logic signed [rlbt_pkg::COORD_BITS-1:0]  in_target_x,
  input  logic signed [rlbt_pkg::COORD_BITS-1:0]  in_target_y,
  input  logic [rlbt_pkg::FIELD_BITS-1:0]         in_new_heading,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [rlbt_pkg::FIELD_BITS-1:0]         out_heading,
  output logic [rlbt_pkg::FIELD_BITS-1:0]         out_bearing,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rlbt_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  logic [rlbt_pkg::RATE_BITS-1:0] turn_rate_r;
  logic                           reg_hit;
  rlbt_pkg::rlbt_cmd_t            cmd;
  rlbt_pkg::rlbt_sts_t            sts;

  assign pready = 1'b1;
  assign reg_hit = (paddr[2:2] == rlbt_pkg::REG_TURN_RATE);
  assign prdata = reg_hit ? 32'(turn_rate_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_rate_r <= rlbt_pkg::TURN_RATE_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      turn_rate_r <= pwdata[rlbt_pkg::RATE_BITS-1:0];
    end
  end

  rlbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rlbt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .turn_rate      (turn_rate_r),
    .in_action      (in_action),
    .in_elapsed_us  (in_elapsed_us),
    .in_own_x       (in_own_x),
    .in_own_y       (in_own_y),
    .in_target_x    (in_target_x),
    .in_target_y    (in_target_y),
    .in_new_heading (in_new_heading),
    .out_heading    (out_heading),
    .out_bearing    (out_bearing)
  );

endmodule

// File: test/tb.sv
// self-checking testbench for rate_limited_bearing_tracker: directed and random tick
// transfers with random idling on both channels, turn rate changed over the apb port
// depends on rlbt_pkg and the rate_limited_bearing_tracker rtl
`timescale 1ns / 100ps

typedef struct {
  logic                                action;
  logic [rlbt_pkg::TIME_BITS-1:0]      elapsed_us;
  logic signed [rlbt_pkg::COORD_BITS-1:0] own_x;
  logic signed [rlbt_pkg::COORD_BITS-1:0] own_y;
  logic signed [rlbt_pkg::COORD_BITS-1:0] target_x;
  logic signed [rlbt_pkg::COORD_BITS-1:0] target_y;
  logic [rlbt_pkg::FIELD_BITS-1:0]     new_heading;
} tick_t;

class heading_checker;
  typedef struct {
    logic [rlbt_pkg::FIELD_BITS-1:0] heading;
    logic [rlbt_pkg::FIELD_BITS-1:0] bearing;
  } result_t;

  logic [rlbt_pkg::RATE_BITS-1:0]  turn_rate;
  logic [rlbt_pkg::FIELD_BITS-1:0] heading;
  logic [31:0]                     atan_turn[30];
  result_t                         pending_q[$];
  int                              mismatches;
  int                              checked;

  function new();
    turn_rate = rlbt_pkg::TURN_RATE_RESET;
    heading = '0;
    mismatches = 0;
    checked = 0;
    atan_turn = '{536870912, 316933406, 167458907, 85004756, 42667331,
                  21354465, 10679838, 5340245, 2670163, 1335087,
                  667544, 333772, 166886, 83443, 41722,
                  20861, 10430, 5215, 2608, 1304,
                  652, 326, 163, 81, 41,
                  20, 10, 5, 3, 1};
  endfunction

  function void set_turn_rate(input logic [rlbt_pkg::RATE_BITS-1:0] rate);
    turn_rate = rate;
  endfunction

  // bearing = -atan2(dx, dy) by vectoring cordic, z in 2^-32 turn
  function logic [15:0] cordic_bearing(input longint dx, input longint dy);
    longint      xv, yv, xs, ys;
    logic [31:0] z;
    logic [32:0] r;
    if (dx == 0 && dy == 0) return '0;
    xv = dy <<< rlbt_pkg::SCALE_SHIFT;
    yv = dx <<< rlbt_pkg::SCALE_SHIFT;
    z = '0;
    if (xv < 0) begin
      xv = -xv;
      yv = -yv;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 30; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        z = z + atan_turn[i];
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        z = z - atan_turn[i];
      end
    end
    r = {1'b0, 32'h0 - z} + 33'h0_0000_8000;
    return r[31:16];
  endfunction

  function logic [15:0] turn_toward(input logic [15:0] bear,
                                    input logic [rlbt_pkg::TIME_BITS-1:0] elapsed);
    logic [15:0] u;
    longint      d, lim;
    u = bear - heading;
    // exactly half a turn counts as positive
    d = (u > 16'h8000) ? longint'(u) - 65536 : longint'(u);
    lim = (longint'(turn_rate) * longint'(elapsed)) / 1000000;
    if (d > lim) d = lim;
    else if (d < -lim) d = -lim;
    return heading + d[15:0];
  endfunction

  function void note_tick(input tick_t t);
    result_t r;
    if (t.action == rlbt_pkg::ACT_LOAD) begin
      heading = t.new_heading;
      r.bearing = '0;
    end else begin
      r.bearing = cordic_bearing(longint'(t.own_x) - longint'(t.target_x),
                                 longint'(t.own_y) - longint'(t.target_y));
      heading = turn_toward(r.bearing, t.elapsed_us);
    end
    r.heading = heading;
    pending_q.push_back(r);
  endfunction

  function void check_result(input logic [15:0] got_heading, input logic [15:0] got_bearing);
    result_t r;
    checked++;
    if (pending_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result heading %0d bearing %0d", $time, got_heading,
               got_bearing);
      return;
    end
    r = pending_q.pop_front();
    if (got_heading !== r.heading) begin
      mismatches++;
      $display("%0t: heading mismatch: expected %0d, got %0d", $time, r.heading,
               got_heading);
    end
    if (got_bearing !== r.bearing) begin
      mismatches++;
      $display("%0t: bearing mismatch: expected %0d, got %0d", $time, r.bearing,
               got_bearing);
    end
  endfunction
endclass

module tb;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_PER_PHASE = 236;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                   in_valid = 1'b0;
  logic                                   in_stall;
  logic                                   in_action = rlbt_pkg::ACT_TRACK;
  logic [rlbt_pkg::TIME_BITS-1:0]         in_elapsed_us = '0;
  logic signed [rlbt_pkg::COORD_BITS-1:0] in_own_x = '0;
  logic signed [rlbt_pkg::COORD_BITS-1:0] in_own_y = '0;
  logic signed [rlbt_pkg::COORD_BITS-1:0] in_target_x = '0;
  logic signed [rlbt_pkg::COORD_BITS-1:0] in_target_y = '0;
  logic [rlbt_pkg::FIELD_BITS-1:0]        in_new_heading = '0;
  logic                                   out_valid;
  logic                                   out_stall = 1'b0;
  logic [rlbt_pkg::FIELD_BITS-1:0]        out_heading;
  logic [rlbt_pkg::FIELD_BITS-1:0]        out_bearing;
  logic                                   psel = 1'b0;
  logic                                   penable = 1'b0;
  logic                                   pwrite = 1'b0;
  logic [rlbt_pkg::ADDR_BITS-1:0]         paddr = '0;
  logic [31:0]                            pwdata = '0;
  logic [31:0]                            prdata;
  logic                                   pready;

  heading_checker sb = new();

  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_track = 0;
  int n_load = 0;
  int n_rates = 0;

  logic signed [rlbt_pkg::COORD_BITS-1:0] scene_ox = '0;
  logic signed [rlbt_pkg::COORD_BITS-1:0] scene_oy = '0;
  logic signed [rlbt_pkg::COORD_BITS-1:0] scene_tx = 24'sd5000;
  logic signed [rlbt_pkg::COORD_BITS-1:0] scene_ty = 24'sd7000;

  rate_limited_bearing_tracker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_elapsed_us(in_elapsed_us), .in_own_x(in_own_x), .in_own_y(in_own_y),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .in_new_heading(in_new_heading),
    .out_valid(out_valid), .out_stall(out_stall), .out_heading(out_heading),
    .out_bearing(out_bearing),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("** rate_limited_bearing_tracker: FAILED **");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_heading, out_bearing);
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  function automatic tick_t track_tick(input int el, input int ox, input int oy,
                                       input int tx, input int ty);
    tick_t t;
    t.action = rlbt_pkg::ACT_TRACK;
    t.elapsed_us = el[rlbt_pkg::TIME_BITS-1:0];
    t.own_x = ox[rlbt_pkg::COORD_BITS-1:0];
    t.own_y = oy[rlbt_pkg::COORD_BITS-1:0];
    t.target_x = tx[rlbt_pkg::COORD_BITS-1:0];
    t.target_y = ty[rlbt_pkg::COORD_BITS-1:0];
    t.new_heading = rlbt_pkg::FIELD_BITS'($urandom());
    return t;
  endfunction

  function automatic tick_t load_tick(input logic [rlbt_pkg::FIELD_BITS-1:0] h);
    tick_t t;
    t.action = rlbt_pkg::ACT_LOAD;
    t.elapsed_us = rlbt_pkg::TIME_BITS'($urandom());
    t.own_x = rlbt_pkg::COORD_BITS'($urandom());
    t.own_y = rlbt_pkg::COORD_BITS'($urandom());
    t.target_x = rlbt_pkg::COORD_BITS'($urandom());
    t.target_y = rlbt_pkg::COORD_BITS'($urandom());
    t.new_heading = h;
    return t;
  endfunction

  // mostly a target tracked over consecutive ticks, with jumps and odd geometry
  function automatic tick_t random_tick();
    tick_t t;
    int    r, q, e;
    r = $urandom_range(99);
    if (r < 12) begin
      if (r < 4)
        return load_tick(sb.cordic_bearing(longint'(scene_ox) - longint'(scene_tx),
                                           longint'(scene_oy) - longint'(scene_ty))
                         + 16'h8000);
      return load_tick(rlbt_pkg::FIELD_BITS'($urandom()));
    end
    q = $urandom_range(99);
    if (q < 8) begin
      scene_ox = rlbt_pkg::COORD_BITS'($urandom());
      scene_oy = rlbt_pkg::COORD_BITS'($urandom());
      scene_tx = rlbt_pkg::COORD_BITS'($urandom());
      scene_ty = rlbt_pkg::COORD_BITS'($urandom());
    end else if (q < 14) begin
      scene_tx = scene_ox;
      scene_ty = scene_oy;
    end else if (q < 20) begin
      if ($urandom_range(1)) scene_tx = scene_ox;
      else scene_ty = scene_oy;
      scene_tx = scene_tx + rlbt_pkg::COORD_BITS'($urandom_range(4096) - 2048);
    end else if (q < 30) begin
      scene_tx = scene_ox + rlbt_pkg::COORD_BITS'($urandom_range(4096) - 2048);
      scene_ty = scene_oy + rlbt_pkg::COORD_BITS'($urandom_range(4096) - 2048);
    end else begin
      scene_ox = scene_ox + rlbt_pkg::COORD_BITS'($urandom_range(64) - 32);
      scene_oy = scene_oy + rlbt_pkg::COORD_BITS'($urandom_range(64) - 32);
      scene_tx = scene_tx + rlbt_pkg::COORD_BITS'($urandom_range(64) - 32);
      scene_ty = scene_ty + rlbt_pkg::COORD_BITS'($urandom_range(64) - 32);
    end
    r = $urandom_range(99);
    if (r < 5) e = 0;
    else if (r < 10) e = $urandom_range((1 << rlbt_pkg::TIME_BITS) - 1);
    else if (r < 15) e = 1000000;
    else e = $urandom_range(100000, 1000);
    t.action = rlbt_pkg::ACT_TRACK;
    t.elapsed_us = e[rlbt_pkg::TIME_BITS-1:0];
    t.own_x = scene_ox;
    t.own_y = scene_oy;
    t.target_x = scene_tx;
    t.target_y = scene_ty;
    t.new_heading = rlbt_pkg::FIELD_BITS'($urandom());
    return t;
  endfunction

  task automatic push_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= t.action;
    in_elapsed_us <= t.elapsed_us;
    in_own_x <= t.own_x;
    in_own_y <= t.own_y;
    in_target_x <= t.target_x;
    in_target_y <= t.target_y;
    in_new_heading <= t.new_heading;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(t);
    if (t.action == rlbt_pkg::ACT_LOAD) n_load++;
    else n_track++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_turn_rate(input logic [rlbt_pkg::RATE_BITS-1:0] rate);
    logic [31:0] junk;
    junk = $urandom();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rlbt_pkg::ADDR_BITS'(4 * rlbt_pkg::REG_TURN_RATE);
    pwdata <= {junk[31:rlbt_pkg::RATE_BITS], rate};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_turn_rate(rate);
    n_rates++;
  endtask

  initial begin
    logic [15:0] bear;
    logic [rlbt_pkg::RATE_BITS-1:0] rate;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset turn rate
    push_tick(load_tick(16'h0000));
    push_tick(track_tick(1000000, 1000, -1000, 1000, -1000));
    push_tick(load_tick(16'h4000));
    push_tick(track_tick(500000, -77, 12, -77, 12));
    push_tick(track_tick(1000000, 8388607, 8388607, -8388608, -8388608));
    push_tick(track_tick(1000000, -8388608, -8388608, 8388607, 8388607));
    push_tick(track_tick(1000000, 8388607, -8388608, -8388608, 8388607));
    push_tick(track_tick(1000000, -8388608, 8388607, 8388607, -8388608));
    push_tick(track_tick(0, 400, 900, -300, 20));
    push_tick(track_tick((1 << rlbt_pkg::TIME_BITS) - 1, 400, 900, -300, 20));
    push_tick(track_tick(300000, 0, 5, 0, 0));
    push_tick(track_tick(300000, 0, -5, 0, 0));
    push_tick(track_tick(300000, 5, 0, 0, 0));
    push_tick(track_tick(300000, -5, 0, 0, 0));
    bear = sb.cordic_bearing(300, -700);
    push_tick(load_tick(bear + 16'h8000));
    push_tick(track_tick(100000, 300, -700, 0, 0));
    push_tick(load_tick(16'hffff));
    drain();

    write_turn_rate(rlbt_pkg::RATE_BITS'((1 << rlbt_pkg::RATE_BITS) - 1));
    push_tick(track_tick((1 << rlbt_pkg::TIME_BITS) - 1, 123456, -654321, -999, 4242));
    push_tick(track_tick(1000000, -500, 2000, 7000, -3));
    push_tick(load_tick(sb.cordic_bearing(300, -700) + 16'h8000));
    push_tick(track_tick(1, 300, -700, 0, 0));
    drain();

    write_turn_rate('0);
    push_tick(track_tick((1 << rlbt_pkg::TIME_BITS) - 1, 2000, 2000, -2000, -2000));
    push_tick(load_tick(16'h5a5a));
    drain();

    // random phases: idling style changes every two turn rate settings
    for (int s = 0; s < 8; s++) begin
      case (s / 2)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 60; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 60; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      case (s)
        0, 7: rate = rlbt_pkg::RATE_BITS'($urandom());
        1: rate = rlbt_pkg::TURN_RATE_RESET;
        2: rate = '0;
        3: rate = rlbt_pkg::RATE_BITS'((1 << rlbt_pkg::RATE_BITS) - 1);
        4: rate = rlbt_pkg::RATE_BITS'($urandom_range(100000, 1000));
        5: rate = rlbt_pkg::RATE_BITS'(65536);
        default: rate = rlbt_pkg::RATE_BITS'(1);
      endcase
      write_turn_rate(rate);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) push_tick(random_tick());
      drain();
    end

    repeat (40) @(posedge clk);
    $display("%0d tick transfers (%0d track, %0d load) under %0d turn rate writes,",
             n_track + n_load, n_track, n_load, n_rates);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("** rate_limited_bearing_tracker: PASSED **");
    end else begin
      $display("** rate_limited_bearing_tracker: FAILED **");
    end
    $finish;
  end

endmodule
